// ===== sv/ines_pkg.sv =====
// ----------------------------------------------------------------------------
// ines_pkg
// shared types and constants of the cartridge image stream parser
// ----------------------------------------------------------------------------
package ines_pkg;

  // default section sizes in bytes
  localparam int PRG_BANK_BYTES_DEF = 16384;
  localparam int CHR_BANK_BYTES_DEF = 8192;
  localparam int TRAINER_BYTES_DEF  = 512;

  // fixed field widths
  localparam int OFFS_W = 14;
  localparam int CNT_W  = OFFS_W;

  // label of each byte
  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_TRAINER = 3'd1,
    KIND_PRG     = 3'd2,
    KIND_CHR     = 3'd3,
    KIND_TRAIL   = 3'd4,
    KIND_REJECT  = 3'd5
  } kind_t;

  // nametable mirroring
  typedef enum logic [1:0] {
    MIR_HORIZ = 2'd0,
    MIR_VERT  = 2'd1,
    MIR_FOUR  = 2'd2
  } mirror_t;

  // one labelled result beat
  typedef struct packed {
    kind_t             kind;
    logic [7:0]        bank_number;
    logic [OFFS_W-1:0] bank_offset;
    logic [7:0]        data_out;
    mirror_t           mirroring;
    logic              battery_ram;
    logic              has_trainer;
    logic [7:0]        mapper_number;
    logic [7:0]        prg_bank_total;
    logic [7:0]        chr_bank_total;
  } res_t;

endpackage

// ===== sv/ines_parse_core.sv =====
// ----------------------------------------------------------------------------
// ines_parse_core
// parse state and per-byte decode: header checks, section and bank tracking
// ----------------------------------------------------------------------------
module ines_parse_core #(
  parameter int PRG_BANK_BYTES = ines_pkg::PRG_BANK_BYTES_DEF,
  parameter int CHR_BANK_BYTES = ines_pkg::CHR_BANK_BYTES_DEF,
  parameter int TRAINER_BYTES  = ines_pkg::TRAINER_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic          sof,
  input  logic [7:0]    byte_in,
  output ines_pkg::res_t res
);
  import ines_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_TRAINER = 3'd1,
    PH_PRG     = 3'd2,
    PH_CHR     = 3'd3,
    PH_TRAIL   = 3'd4,
    PH_REJECT  = 3'd5
  } phase_t;

  localparam logic [CNT_W:0] HDR_LIM = (CNT_W+1)'(16);
  localparam logic [CNT_W:0] TRN_LIM = (CNT_W+1)'(TRAINER_BYTES);
  localparam logic [CNT_W:0] PRG_LIM = (CNT_W+1)'(PRG_BANK_BYTES);
  localparam logic [CNT_W:0] CHR_LIM = (CNT_W+1)'(CHR_BANK_BYTES);
  localparam logic [3:0][7:0] MAGIC  = {8'h1A, 8'h53, 8'h45, 8'h4E};

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       bank_r, bank_nxt;
  logic [7:0]       prg_r, prg_nxt;
  logic [7:0]       chr_r, chr_nxt;
  logic [3:0]       flags_r, flags_nxt;
  logic [7:0]       mapper_r, mapper_nxt;

  // state as seen by this byte, a start mark clears it
  phase_t           ph_e;
  logic [CNT_W-1:0] cnt_e;
  logic [7:0]       bank_e, prg_e, chr_e, mapper_e;
  logic [3:0]       flags_e;
  logic [CNT_W:0]   cnt_inc;
  logic [7:0]       bank_inc;
  kind_t            kind;
  logic [7:0]       res_bank;
  logic [CNT_W-1:0] res_offs;

  // first section present at or after a given phase
  function automatic phase_t next_section(input phase_t from, input logic [3:0] flg,
                                          input logic [7:0] prg, input logic [7:0] chr);
    phase_t ph;
    if (from <= PH_TRAINER && flg[2])        ph = PH_TRAINER;
    else if (from <= PH_PRG && prg != 8'd0)  ph = PH_PRG;
    else if (from <= PH_CHR && chr != 8'd0)  ph = PH_CHR;
    else                                     ph = PH_TRAIL;
    return ph;
  endfunction

  always_comb begin
    ph_e     = sof ? PH_HEADER : phase_r;
    cnt_e    = sof ? '0 : cnt_r;
    bank_e   = sof ? '0 : bank_r;
    prg_e    = sof ? '0 : prg_r;
    chr_e    = sof ? '0 : chr_r;
    flags_e  = sof ? '0 : flags_r;
    mapper_e = sof ? '0 : mapper_r;
  end

  assign cnt_inc  = {1'b0, cnt_e} + (CNT_W+1)'(1);
  assign bank_inc = bank_e + 8'd1;

  // per-byte decode and next state
  always_comb begin
    phase_nxt  = ph_e;
    cnt_nxt    = cnt_e;
    bank_nxt   = bank_e;
    prg_nxt    = prg_e;
    chr_nxt    = chr_e;
    flags_nxt  = flags_e;
    mapper_nxt = mapper_e;
    kind       = KIND_TRAIL;
    res_bank   = '0;
    res_offs   = '0;
    case (ph_e)
      PH_HEADER: begin
        kind = KIND_HEADER;
        if (cnt_e < CNT_W'(4) && byte_in != MAGIC[cnt_e[1:0]]) begin
          kind      = KIND_REJECT;
          phase_nxt = PH_REJECT;
        end else begin
          if (cnt_e == CNT_W'(4)) prg_nxt = byte_in;
          if (cnt_e == CNT_W'(5)) chr_nxt = byte_in;
          if (cnt_e == CNT_W'(6)) begin
            flags_nxt  = byte_in[3:0];
            mapper_nxt = {4'd0, byte_in[7:4]};
          end
          if (cnt_e == CNT_W'(7)) mapper_nxt = {byte_in[7:4], mapper_e[3:0]};
          cnt_nxt = cnt_inc[CNT_W-1:0];
          if (cnt_inc >= HDR_LIM) begin
            cnt_nxt   = '0;
            bank_nxt  = '0;
            phase_nxt = next_section(PH_TRAINER, flags_nxt, prg_nxt, chr_nxt);
          end
        end
      end
      PH_TRAINER: begin
        kind    = KIND_TRAINER;
        cnt_nxt = cnt_inc[CNT_W-1:0];
        if (cnt_inc >= TRN_LIM) begin
          cnt_nxt   = '0;
          bank_nxt  = '0;
          phase_nxt = next_section(PH_PRG, flags_e, prg_e, chr_e);
        end
      end
      PH_PRG, PH_CHR: begin
        kind     = (ph_e == PH_PRG) ? KIND_PRG : KIND_CHR;
        res_bank = bank_e;
        res_offs = cnt_e;
        cnt_nxt  = cnt_inc[CNT_W-1:0];
        if (cnt_inc >= ((ph_e == PH_PRG) ? PRG_LIM : CHR_LIM)) begin
          cnt_nxt  = '0;
          bank_nxt = bank_inc;
          if (bank_inc >= ((ph_e == PH_PRG) ? prg_e : chr_e)) begin
            bank_nxt  = '0;
            phase_nxt = next_section((ph_e == PH_PRG) ? PH_CHR : PH_TRAIL,
                                     flags_e, prg_e, chr_e);
          end
        end
      end
      PH_REJECT: kind = KIND_REJECT;
      default:   kind = KIND_TRAIL;
    endcase
  end

  // decoded header fields of the result show the state after this byte
  always_comb begin
    res.kind           = kind;
    res.bank_number    = res_bank;
    res.bank_offset    = res_offs;
    res.data_out       = byte_in;
    res.mirroring      = flags_nxt[3] ? MIR_FOUR : (flags_nxt[0] ? MIR_VERT : MIR_HORIZ);
    res.battery_ram    = flags_nxt[1];
    res.has_trainer    = flags_nxt[2];
    res.mapper_number  = mapper_nxt;
    res.prg_bank_total = prg_nxt;
    res.chr_bank_total = chr_nxt;
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      cnt_r    <= '0;
      bank_r   <= '0;
      prg_r    <= '0;
      chr_r    <= '0;
      flags_r  <= '0;
      mapper_r <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      bank_r   <= bank_nxt;
      prg_r    <= prg_nxt;
      chr_r    <= chr_nxt;
      flags_r  <= flags_nxt;
      mapper_r <= mapper_nxt;
    end
  end

  // a data section is only ever entered with a nonzero bank count
  a_prg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PRG |-> prg_r != 8'd0)
    else $error("prg phase with zero bank count");

  a_chr_bank: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_CHR |-> bank_r < chr_r)
    else $error("chr bank counter beyond total");

  a_counter_clear: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_nxt != ph_e && phase_nxt != PH_REJECT |=> cnt_r == '0 && bank_r == '0)
    else $error("counters not cleared on section change");

endmodule

// ===== sv/ines_image_stream_parser.sv =====
// A byte accepted into the input register is decoded and written into the result
// register, from which its result beat is offered.
// Throughput: one byte per cycle while the output is not stalled, set by the
// single-pass decode between the input register and the result register; a
// stalled output still lets the input register fill once.
// Reset: synchronous, active low; clears both valid flags and all parse state.
// ----------------------------------------------------------------------------
// ines_image_stream_parser
// labels each byte of a cartridge image and decodes its 16-byte header
// ----------------------------------------------------------------------------
module ines_image_stream_parser #(
  parameter int PRG_BANK_BYTES = ines_pkg::PRG_BANK_BYTES_DEF,
  parameter int CHR_BANK_BYTES = ines_pkg::CHR_BANK_BYTES_DEF,
  parameter int TRAINER_BYTES  = ines_pkg::TRAINER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  input  logic [0:0]  in_tuser,   // [0] start_of_file
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [7:0] bank_number, [21:8] bank_offset,
                                  // [29:22] data_out, [31:30] mirroring,
                                  // [32] battery_ram, [33] has_trainer,
                                  // [41:34] mapper_number, [49:42] prg_bank_total,
                                  // [57:50] chr_bank_total, [63:58] zero
  output logic [2:0]  out_tuser   // [2:0] byte_kind
);
  import ines_pkg::*;

  logic       s1_valid_r;
  logic       s1_sof_r;
  logic [7:0] s1_byte_r;
  logic       s1_fire;
  logic       out_valid_r;
  res_t       out_res_r;
  res_t       res;

  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_sof_r  <= in_tuser[0];
      s1_byte_r <= in_tdata;
    end
  end

  ines_parse_core #(
    .PRG_BANK_BYTES(PRG_BANK_BYTES),
    .CHR_BANK_BYTES(CHR_BANK_BYTES),
    .TRAINER_BYTES (TRAINER_BYTES)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_fire),
    .sof    (s1_sof_r),
    .byte_in(s1_byte_r),
    .res    (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= res;
    end
  end

  // pack the result beat
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {6'd0, out_res_r.chr_bank_total, out_res_r.prg_bank_total,
                       out_res_r.mapper_number, out_res_r.has_trainer,
                       out_res_r.battery_ram, out_res_r.mirroring, out_res_r.data_out,
                       out_res_r.bank_offset, out_res_r.bank_number};

  a_prg_bank_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.kind == KIND_PRG |->
      out_res_r.bank_number < out_res_r.prg_bank_total)
    else $error("prg bank beyond header total");

  a_nondata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.kind != KIND_PRG && out_res_r.kind != KIND_CHR |->
      out_res_r.bank_number == 8'd0 && out_res_r.bank_offset == '0)
    else $error("bank position on a non-data byte");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !s1_valid_r)
    else $error("valid after reset");

endmodule
